/* src/srcl_pkg.sv */
// Shared types, constants and helpers for the sector run coalescer.
package srcl_pkg;

  // Device byte flag bits.
  localparam logic [7:0] LBA_FLAG_MASK    = 8'd32;
  localparam logic [7:0] NOCOUNT_MASK     = 8'd16;
  localparam logic [7:0] LINEAR_FLAG_MASK = 8'd64;

  // Transfer limits for a run, in sectors.
  localparam logic [7:0] XFER_MAX_LBA = 8'd127;
  localparam logic [7:0] XFER_MAX_STD = 8'd128;

  // Load window tracking: byte position advances one sector per comparison.
  localparam int unsigned    POS_W        = 24;
  localparam logic [POS_W-1:0] SECTOR_BYTES = 24'd512;

  // Remembered high address byte; the reset value never matches a count.
  localparam logic [8:0] HIGH_PART_RESET = 9'd257;

  // Depth of the queue between the merge engine and the emitter.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register indexes on the configuration port.
  localparam logic REG_SKIP_ENTRIES = 1'b0;
  localparam logic REG_LBA_MODE     = 1'b1;

  typedef struct packed {
    logic [7:0] dev_code;
    logic [7:0] head_byte;
    logic [7:0] track_byte;
    logic [7:0] sector_byte;
    logic [7:0] run_count;
    logic       list_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_dev;
    logic [7:0] out_head;
    logic [7:0] out_track;
    logic [7:0] out_sector;
    logic [7:0] out_count;
    logic       out_last;
  } out_item_t;

  typedef struct packed {
    logic [7:0] dev;
    logic [7:0] head;
    logic [7:0] track;
    logic [7:0] sector;
    logic [7:0] count;
  } rec_t;

  // One queue entry: the one or two records caused by one input item.
  typedef struct packed {
    out_item_t rec0;
    out_item_t rec1;
    logic      two;
  } entry_t;

  typedef struct packed {
    logic [7:0] skip_entries;
    logic       lba_mode;
  } cfg_t;

  typedef struct packed {
    logic held_valid;
    logic merged;
  } front_stat_t;

  function automatic out_item_t to_out(rec_t r, logic last);
    out_item_t o;
    o.out_dev    = r.dev;
    o.out_head   = r.head;
    o.out_track  = r.track;
    o.out_sector = r.sector;
    o.out_count  = r.count;
    o.out_last   = last;
    return o;
  endfunction

endpackage

/* src/sector_run_coalescer.sv */
// Top level of the sector run coalescer: configuration registers, merge engine, queue, emitter.
//
// The coalescer takes disk sector address records and merges each one into the
// run it holds when the two are on the same device and follow on, either as
// 24-bit block addresses (linear and large-block records) or by head, track and
// sector (geometry records). A run stops growing at the transfer limit (127
// sectors with lba_mode set, 128 otherwise) and at a 64 KiB load-window
// boundary. The first skip_entries+1 records of a section pass through as they
// are, and the record marked list_end flushes the held run, so one record can
// give up to two results. A record is accepted in every cycle in which full is
// low; the merge decision is one compare and add against the held run and is
// made in the cycle of acceptance. Results leave one beat per cycle while pop
// is high; the engine writes results into a four-entry queue, and the emitter
// moves the oldest entry into the output register, so a result passes the
// queue and then the output register before it is on the output ports. full
// rises only when that queue is full, which can happen only while results are
// not being taken or while records produce two results each faster than they
// drain. After reset the block is ready at once; there is no clearing pass.
// Registers: skip_entries at byte address 0 (bits 7:0) and lba_mode at byte
// address 4 (bit 0); write them only while the block is idle.
module sector_run_coalescer (
  input  logic                clk,
  input  logic                rst_n,
  // Record input.
  input  logic                push,
  output logic                full,
  input  srcl_pkg::in_item_t  in_data,
  // Result output.
  output logic                empty,
  input  logic                pop,
  output srcl_pkg::out_item_t out_data,
  // Configuration port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  srcl_pkg::cfg_t        cfg_r, cfg_nxt;
  srcl_pkg::entry_t      q_entry, q_data;
  srcl_pkg::front_stat_t front_stat;
  logic                  in_accept;
  logic                  q_push, q_pop, q_full, q_empty;
  logic                  cfg_write;

  // The APB-style port never waits; a write lands in the access cycle.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_write) begin
      unique case (paddr[2])
        srcl_pkg::REG_SKIP_ENTRIES: cfg_nxt.skip_entries = pwdata[7:0];
        srcl_pkg::REG_LBA_MODE:     cfg_nxt.lba_mode     = pwdata[0];
        default:                    cfg_nxt              = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      srcl_pkg::REG_SKIP_ENTRIES: prdata = {24'd0, cfg_r.skip_entries};
      srcl_pkg::REG_LBA_MODE:     prdata = {31'd0, cfg_r.lba_mode};
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // A record is taken whenever the queue has room, even if it causes no result.
  assign full      = q_full;
  assign in_accept = push && !q_full;

  srcl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_accept (in_accept),
    .in_item   (in_data),
    .q_push    (q_push),
    .q_entry   (q_entry),
    .stat      (front_stat)
  );

  srcl_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_entry),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_data)
  );

  srcl_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

`ifndef SYNTHESIS
  // A waiting queue entry reaches the output register in the next cycle.
  a_drain_to_output: assert property (@(posedge clk) disable iff (!rst_n)
    (!q_empty && empty) |=> !empty)
    else $error("queued result did not reach the output");

  // No beat appears out of nothing.
  a_no_invented_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (empty && q_empty && !q_push) |=> empty)
    else $error("output beat appeared without a queued result");

  // The end of a section leaves no run held.
  a_section_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_data.list_end) |=> !front_stat.held_valid)
    else $error("run still held after the end of a section");

  // A merge extends the held run and emits nothing unless the section ends.
  a_merge_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    front_stat.merged |-> (front_stat.held_valid && (!q_push || in_data.list_end)))
    else $error("merge produced an unexpected result");
`endif

endmodule

/* src/srcl_queue.sv */
// Small register queue of result entries between the merge engine and the emitter.
module srcl_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  srcl_pkg::entry_t wdata,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output srcl_pkg::entry_t rdata
);

  srcl_pkg::entry_t                     mem_r [srcl_pkg::QUEUE_DEPTH];
  logic [srcl_pkg::QPTR_W-1:0]          wr_ptr_r, wr_ptr_nxt;
  logic [srcl_pkg::QPTR_W-1:0]          rd_ptr_r, rd_ptr_nxt;
  logic [srcl_pkg::QCNT_W-1:0]          count_r, count_nxt;
  logic                                 do_push, do_pop;

  localparam logic [srcl_pkg::QPTR_W-1:0] PTR_LAST = srcl_pkg::QPTR_W'(srcl_pkg::QUEUE_DEPTH - 1);
  localparam logic [srcl_pkg::QCNT_W-1:0] CNT_FULL = srcl_pkg::QCNT_W'(srcl_pkg::QUEUE_DEPTH);

  assign full    = (count_r == CNT_FULL);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

/* src/srcl_front.sv */
// Merge engine: classifies each accepted record against the held run and queues results.
module srcl_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  srcl_pkg::cfg_t        cfg,
  input  logic                  in_accept,
  input  srcl_pkg::in_item_t    in_item,
  output logic                  q_push,
  output srcl_pkg::entry_t      q_entry,
  output srcl_pkg::front_stat_t stat
);

  srcl_pkg::rec_t           held_r, held_nxt;
  logic                     held_valid_r, held_valid_nxt;
  logic [8:0]               entry_idx_r, entry_idx_nxt;
  logic [8:0]               high_part_r, high_part_nxt;
  logic [7:0]               run_start_r, run_start_nxt;
  logic [srcl_pkg::POS_W-1:0] scan_r, scan_nxt;

  always_comb begin
    srcl_pkg::rec_t           n;
    srcl_pkg::rec_t           n_mod;
    srcl_pkg::rec_t           grown;
    logic                     last;
    logic                     same_dev, w_lba, w_nc, w_addr_mode;
    logic                     adj_dev, conv, hp_load, adj_addr, adj;
    logic [24:0]              addr_sum;
    logic [8:0]               sect_sum;
    logic [7:0]               max_count;
    logic [srcl_pkg::POS_W-1:0] scan_step;
    logic                     merged;

    n.dev    = in_item.dev_code;
    n.head   = in_item.head_byte;
    n.track  = in_item.track_byte;
    n.sector = in_item.sector_byte;
    n.count  = in_item.run_count;
    last     = in_item.list_end;

    // Same device, ignoring the no-count flag.
    same_dev = ((held_r.dev ^ n.dev) & ~srcl_pkg::NOCOUNT_MASK) == 8'd0;
    w_lba    = (held_r.dev & srcl_pkg::LBA_FLAG_MASK) != 8'd0;
    w_nc     = (held_r.dev & srcl_pkg::NOCOUNT_MASK) != 8'd0;

    adj_dev = same_dev;
    conv    = 1'b0;
    hp_load = 1'b0;
    if (same_dev && w_lba) begin
      if (!w_nc) begin
        adj_dev = (high_part_r == {1'b0, n.count});
        conv    = adj_dev;
      end else begin
        // A held no-count record is never extended; it updates the high byte.
        adj_dev = 1'b0;
        hp_load = 1'b1;
        conv    = ((n.dev & srcl_pkg::NOCOUNT_MASK) != 8'd0) && (n.count == held_r.count);
      end
    end

    n_mod = n;
    if (conv) begin
      n_mod.count = 8'd1;
      n_mod.dev   = n.dev & ~srcl_pkg::NOCOUNT_MASK;
    end

    // Contiguity: sums kept one bit wider so that an overflow never matches.
    w_addr_mode = (held_r.dev & (srcl_pkg::LINEAR_FLAG_MASK | srcl_pkg::LBA_FLAG_MASK)) != 8'd0;
    addr_sum = {1'b0, held_r.head, held_r.track, held_r.sector} + {17'd0, held_r.count};
    sect_sum = {1'b0, held_r.sector} + {1'b0, held_r.count};
    if (adj_dev && w_addr_mode) begin
      adj_addr = (addr_sum == {1'b0, n.head, n.track, n.sector});
    end else begin
      adj_addr = adj_dev && (held_r.track == n.track) && (held_r.head == n.head) &&
                 (sect_sum == {1'b0, n.sector});
    end

    scan_step = scan_r + srcl_pkg::SECTOR_BYTES;
    max_count = cfg.lba_mode ? srcl_pkg::XFER_MAX_LBA : srcl_pkg::XFER_MAX_STD;
    adj = adj_addr && (run_start_r == scan_step[srcl_pkg::POS_W-1:16]) &&
          (held_r.count < max_count);

    grown       = held_r;
    grown.count = held_r.count + 8'd1;

    held_nxt       = held_r;
    held_valid_nxt = held_valid_r;
    entry_idx_nxt  = entry_idx_r;
    high_part_nxt  = high_part_r;
    run_start_nxt  = run_start_r;
    scan_nxt       = scan_r;
    q_push         = 1'b0;
    q_entry        = '0;
    merged         = 1'b0;

    if (in_accept) begin
      if (!held_valid_r && (entry_idx_r <= {1'b0, cfg.skip_entries})) begin
        q_push       = 1'b1;
        q_entry.rec0 = srcl_pkg::to_out(n, last);
        entry_idx_nxt = entry_idx_r + 9'd1;
      end else if (!held_valid_r) begin
        held_nxt       = n;
        held_valid_nxt = 1'b1;
        if (last) begin
          q_push       = 1'b1;
          q_entry.rec0 = srcl_pkg::to_out(n, 1'b1);
        end
      end else begin
        scan_nxt = scan_step;
        if (hp_load) begin
          high_part_nxt = {1'b0, held_r.count};
        end
        if (!adj) begin
          run_start_nxt = scan_step[srcl_pkg::POS_W-1:16];
          held_nxt      = n_mod;
          q_push        = 1'b1;
          q_entry.rec0  = srcl_pkg::to_out(held_r, 1'b0);
          if (last) begin
            q_entry.rec1 = srcl_pkg::to_out(n_mod, 1'b1);
            q_entry.two  = 1'b1;
          end
        end else begin
          merged   = 1'b1;
          held_nxt = grown;
          if (last) begin
            q_push       = 1'b1;
            q_entry.rec0 = srcl_pkg::to_out(grown, 1'b1);
          end
        end
      end

      // The end of a section returns all run state to its reset value.
      if (last) begin
        held_nxt       = '0;
        held_valid_nxt = 1'b0;
        entry_idx_nxt  = '0;
        high_part_nxt  = srcl_pkg::HIGH_PART_RESET;
        run_start_nxt  = '0;
        scan_nxt       = '0;
      end
    end

    stat.held_valid = held_valid_r;
    stat.merged     = merged;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r       <= '0;
      held_valid_r <= 1'b0;
      entry_idx_r  <= '0;
      high_part_r  <= srcl_pkg::HIGH_PART_RESET;
      run_start_r  <= '0;
      scan_r       <= '0;
    end else begin
      held_r       <= held_nxt;
      held_valid_r <= held_valid_nxt;
      entry_idx_r  <= entry_idx_nxt;
      high_part_r  <= high_part_nxt;
      run_start_r  <= run_start_nxt;
      scan_r       <= scan_nxt;
    end
  end

endmodule

/* src/srcl_back.sv */
// Emitter: takes queue entries into an output register and hands out one record per beat.
module srcl_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  srcl_pkg::entry_t    q_data,
  output logic                q_pop,
  output logic                empty,
  input  logic                pop,
  output srcl_pkg::out_item_t out_data
);

  srcl_pkg::entry_t cur_r, cur_nxt;
  logic             cur_valid_r, cur_valid_nxt;
  logic             sel_r, sel_nxt;

  assign empty    = !cur_valid_r;
  assign out_data = sel_r ? cur_r.rec1 : cur_r.rec0;

  always_comb begin
    logic taken, entry_done;
    taken      = cur_valid_r && pop;
    entry_done = taken && (sel_r || !cur_r.two);

    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    sel_nxt       = sel_r;
    q_pop         = 1'b0;

    if (taken && !sel_r && cur_r.two) begin
      sel_nxt = 1'b1;
    end
    if (!cur_valid_r || entry_done) begin
      sel_nxt = 1'b0;
      if (!q_empty) begin
        q_pop         = 1'b1;
        cur_nxt       = q_data;
        cur_valid_nxt = 1'b1;
      end else begin
        cur_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      sel_r       <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      sel_r       <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

endmodule

/* test/sector_run_coalescer_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the sector run coalescer: directed and random record streams.
module sector_run_coalescer_tb;

  // Shapes of record sections that the random part builds.
  typedef enum int {RUN_GEO, RUN_LIN, RUN_LBA, RUN_NOISE} run_kind_t;

  logic                clk;
  logic                rst_n   = 1'b0;
  logic                push    = 1'b0;
  logic                full;
  srcl_pkg::in_item_t  in_data = '0;
  logic                empty;
  logic                pop     = 1'b0;
  srcl_pkg::out_item_t out_data;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [2:0]          paddr   = '0;
  logic [31:0]         pwdata  = '0;
  logic [31:0]         prdata;
  logic                pready;

  sector_run_coalescer DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .empty   (empty),
    .pop     (pop),
    .out_data(out_data),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Records waiting to be sent, and result beats that the block still owes us.
  srcl_pkg::in_item_t  records_to_send[$];
  srcl_pkg::out_item_t beats_due[$];
  int unsigned records_queued = 0;
  int unsigned records_taken  = 0;
  int unsigned mismatches     = 0;

  // Percentages of cycles in which each side holds back.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // Our own copy of the configuration registers.
  logic [7:0] skip_limit      = 8'd0;
  logic       wide_block_mode = 1'b0;

  // Our own copy of the merge state. These are the values a fresh section starts from.
  srcl_pkg::rec_t held_run        = '0;
  logic           run_open        = 1'b0;
  logic [8:0]     section_entries = 9'd0;
  logic [8:0]     upper_byte      = srcl_pkg::HIGH_PART_RESET;
  logic [23:0]    window_start    = 24'd0;
  logic [23:0]    window_pos      = 24'd0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic log_mismatch(string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic expect_record(srcl_pkg::rec_t r, logic last);
    srcl_pkg::out_item_t b;
    b.out_dev    = r.dev;
    b.out_head   = r.head;
    b.out_track  = r.track;
    b.out_sector = r.sector;
    b.out_count  = r.count;
    b.out_last   = last;
    beats_due.push_back(b);
  endtask

  task automatic close_section();
    held_run        = '0;
    run_open        = 1'b0;
    section_entries = 9'd0;
    upper_byte      = srcl_pkg::HIGH_PART_RESET;
    window_start    = 24'd0;
    window_pos      = 24'd0;
  endtask

  // Works out the result beats that one accepted record causes and updates our state.
  task automatic coalesce_record(srcl_pkg::in_item_t it);
    srcl_pkg::rec_t nr;
    logic           linked;
    logic [7:0]     limit;
    logic [8:0]     sector_sum;
    logic [31:0]    addr_sum;
    nr.dev    = it.dev_code;
    nr.head   = it.head_byte;
    nr.track  = it.track_byte;
    nr.sector = it.sector_byte;
    nr.count  = it.run_count;

    if (!run_open && section_entries <= {1'b0, skip_limit}) begin
      // Still in the leading records of the section: they go out as they came.
      expect_record(nr, it.list_end);
      section_entries++;
    end else if (!run_open) begin
      held_run = nr;
      run_open = 1'b1;
    end else begin
      limit  = wide_block_mode ? srcl_pkg::XFER_MAX_LBA : srcl_pkg::XFER_MAX_STD;
      // Same device means equal device bytes once the no-count flag is masked off.
      linked = ((held_run.dev ^ nr.dev) & ~srcl_pkg::NOCOUNT_MASK) == 8'd0;

      // Large-block runs: the upper address byte must agree. A record that carries it
      // in its count field is turned into a one-sector record, merged or not.
      if (linked && (held_run.dev & srcl_pkg::LBA_FLAG_MASK) != 8'd0) begin
        if ((held_run.dev & srcl_pkg::NOCOUNT_MASK) == 8'd0) begin
          linked = (upper_byte == {1'b0, nr.count});
          if (linked) begin
            nr.count = 8'd1;
            nr.dev   = nr.dev & ~srcl_pkg::NOCOUNT_MASK;
          end
        end else begin
          linked     = 1'b0;
          upper_byte = {1'b0, held_run.count};
          if ((nr.dev & srcl_pkg::NOCOUNT_MASK) != 8'd0 &&
              {1'b0, nr.count} == upper_byte) begin
            nr.count = 8'd1;
            nr.dev   = nr.dev & ~srcl_pkg::NOCOUNT_MASK;
          end
        end
      end

      // Follow-on test, done at full width so that a sum that overflows never matches.
      if (linked && (held_run.dev & (srcl_pkg::LINEAR_FLAG_MASK | srcl_pkg::LBA_FLAG_MASK))
          != 8'd0) begin
        addr_sum = {8'd0, held_run.head, held_run.track, held_run.sector} +
                   {24'd0, held_run.count};
        linked   = (addr_sum == {8'd0, nr.head, nr.track, nr.sector});
      end else begin
        sector_sum = {1'b0, held_run.sector} + {1'b0, held_run.count};
        linked     = linked && held_run.track == nr.track && held_run.head == nr.head &&
                     sector_sum == {1'b0, nr.sector};
      end

      // Every comparison moves the load position on by one sector; a run must stay
      // inside the 64 KiB window it started in and below the transfer limit.
      window_pos = window_pos + srcl_pkg::SECTOR_BYTES;
      linked     = linked && window_start[23:16] == window_pos[23:16] &&
                   held_run.count < limit;

      if (!linked) begin
        window_start = window_pos;
        expect_record(held_run, 1'b0);
        held_run = nr;
      end else begin
        held_run.count = held_run.count + 8'd1;
      end
    end

    // The last record of a section flushes whatever run is held.
    if (it.list_end) begin
      if (run_open) expect_record(held_run, 1'b1);
      close_section();
    end
  endtask

  task automatic check_field(string field, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      log_mismatch($sformatf("%s is %02h, expected %02h", field, got, want));
  endtask

  task automatic check_beat(srcl_pkg::out_item_t got);
    srcl_pkg::out_item_t want;
    if (beats_due.size() == 0) begin
      log_mismatch($sformatf("result beat %h arrived with nothing expected", got));
    end else begin
      want = beats_due.pop_front();
      check_field("out_dev", got.out_dev, want.out_dev);
      check_field("out_head", got.out_head, want.out_head);
      check_field("out_track", got.out_track, want.out_track);
      check_field("out_sector", got.out_sector, want.out_sector);
      check_field("out_count", got.out_count, want.out_count);
      check_field("out_last", {7'd0, got.out_last}, {7'd0, want.out_last});
    end
  endtask

  // Driver. A record counts as sent at the edge where push is high and full is low;
  // the prediction is made right there. push stays up while the block is full.
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        coalesce_record(in_data);
        records_taken++;
      end
      if (!push || !full) begin
        if (records_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= records_to_send.pop_front();
          push    <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor. A result beat is taken at the edge where pop is high and empty is low.
  // Results pass the queue and the output register after their record is taken,
  // so the expectation is always in place by the time its beat can be taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_beat(out_data);
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic enqueue(srcl_pkg::in_item_t it);
    records_to_send.push_back(it);
    records_queued++;
  endtask

  task automatic add_item(logic [7:0] dev, logic [7:0] head, logic [7:0] track,
                          logic [7:0] sector, logic [7:0] count, logic last);
    srcl_pkg::in_item_t it;
    it.dev_code    = dev;
    it.head_byte   = head;
    it.track_byte  = track;
    it.sector_byte = sector;
    it.run_count   = count;
    it.list_end    = last;
    enqueue(it);
  endtask

  // Builds one section of records. In all kinds but RUN_NOISE most records follow on from
  // the one before so runs really grow; a few are random noise that breaks the run at some point.
  task automatic queue_section(run_kind_t kind, int unsigned len, bit close_it);
    srcl_pkg::in_item_t it;
    logic [63:0]        raw;
    logic [7:0]         dev;
    logic [7:0]         hi;
    logic [23:0]        addr;
    int unsigned        i;
    dev  = 8'($urandom_range(255));
    hi   = 8'($urandom_range(255));
    addr = 24'($urandom);
    case (kind)
      RUN_GEO: dev = dev & ~(srcl_pkg::LINEAR_FLAG_MASK | srcl_pkg::LBA_FLAG_MASK);
      RUN_LIN: dev = (dev | srcl_pkg::LINEAR_FLAG_MASK) & ~srcl_pkg::LBA_FLAG_MASK;
      default: dev = dev | srcl_pkg::LBA_FLAG_MASK;
    endcase
    dev = dev & ~srcl_pkg::NOCOUNT_MASK;
    for (i = 0; i < len; i++) begin
      if (kind == RUN_NOISE || $urandom_range(99) < 6) begin
        raw         = {$urandom, $urandom};
        it          = raw[$bits(srcl_pkg::in_item_t)-1:0];
        it.list_end = ($urandom_range(99) < 4);
      end else begin
        it.dev_code    = dev;
        it.head_byte   = addr[23:16];
        it.track_byte  = addr[15:8];
        it.sector_byte = addr[7:0];
        it.list_end    = 1'b0;
        if (kind == RUN_LBA) begin
          if (i == 0 || $urandom_range(99) < 5) begin
            // A no-count record sets the upper address byte for what follows.
            if (i != 0 && $urandom_range(1)) hi = 8'($urandom_range(255));
            it.dev_code  = dev | srcl_pkg::NOCOUNT_MASK;
            it.run_count = hi;
          end else begin
            // Records that repeat the upper byte turn into one-sector records.
            if ($urandom_range(99) < 80) it.dev_code = dev | srcl_pkg::NOCOUNT_MASK;
            it.run_count = ($urandom_range(99) < 95) ? hi : 8'($urandom_range(255));
            addr = addr + 24'd1;
          end
        end else begin
          it.run_count = ($urandom_range(99) < 85) ? 8'd1 : 8'($urandom_range(8));
          if ($urandom_range(99) < 20) it.dev_code = dev | srcl_pkg::NOCOUNT_MASK;
          // Geometry records only step the sector byte, which wraps on its own.
          if (kind == RUN_GEO) addr[7:0] = addr[7:0] + it.run_count;
          else addr = addr + {16'd0, it.run_count};
        end
      end
      if (close_it && i == len - 1) it.list_end = 1'b1;
      enqueue(it);
    end
  endtask

  // Queues closed sections until about the given number of records is waiting.
  // Most sections are short; a tenth are 100 to 160 records long and can run past the transfer limit and the window.
  task automatic fill_random(int unsigned target);
    int unsigned goal;
    int unsigned pick;
    int unsigned len;
    run_kind_t   kind;
    goal = records_queued + target;
    while (records_queued < goal) begin
      pick = $urandom_range(99);
      if (pick < 30) kind = RUN_GEO;
      else if (pick < 55) kind = RUN_LIN;
      else if (pick < 85) kind = RUN_LBA;
      else kind = RUN_NOISE;
      pick = $urandom_range(99);
      if (pick < 70) len = $urandom_range(20, 1);
      else if (pick < 90) len = $urandom_range(60, 21);
      else len = $urandom_range(160, 100);
      queue_section(kind, len, 1'b1);
    end
  endtask

  // Lets every queued record go in and every owed beat come out, then lets the clock
  // run on in case the last records caused no result and are still in flight.
  task automatic wait_quiet();
    while (records_taken != records_queued) @(posedge clk);
    while (beats_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle until pready; only while idle.
  task automatic set_register(logic idx, logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == srcl_pkg::REG_SKIP_ENTRIES) skip_limit = value[7:0];
    else wide_block_mode = value[0];
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part with the reset settings: one leading record passed through, 128-sector limit.
    send_idle_pct = 35;
    recv_idle_pct = 55;
    // All-zero and all-one records, each a section of its own.
    add_item(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
    add_item(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    // Geometry run: one pass-through, then merges, a record with the no-count flag
    // that still counts as the same device, a track change, and a sector sum past 255.
    add_item(8'h01, 8'd2, 8'd3, 8'd10, 8'd1, 1'b0);
    add_item(8'h01, 8'd2, 8'd3, 8'd20, 8'd2, 1'b0);
    add_item(8'h01, 8'd2, 8'd3, 8'd22, 8'd1, 1'b0);
    add_item(8'h01, 8'd2, 8'd3, 8'd23, 8'd1, 1'b0);
    add_item(8'h11, 8'd2, 8'd3, 8'd24, 8'd1, 1'b0);
    add_item(8'h01, 8'd2, 8'd4, 8'd25, 8'd1, 1'b0);
    add_item(8'h01, 8'd2, 8'd4, 8'd255, 8'd1, 1'b0);
    add_item(8'h01, 8'd2, 8'd4, 8'd0, 8'd1, 1'b0);
    // Linear run across a 64K address step, then an address sum past 24 bits on the
    // last record, which gives two results at once.
    add_item(8'h41, 8'h00, 8'hFF, 8'hFF, 8'd1, 1'b0);
    add_item(8'h41, 8'h01, 8'h00, 8'h00, 8'd1, 1'b0);
    add_item(8'h41, 8'hFF, 8'hFF, 8'hFF, 8'd1, 1'b0);
    add_item(8'h41, 8'h00, 8'h00, 8'h00, 8'd1, 1'b1);
    // Large-block run: the no-count record with the upper byte, the conversion of a
    // repeat, merges with and without the flag, a different upper byte, and a
    // device change on the last record.
    add_item(8'h30, 8'd0, 8'd0, 8'd5, 8'd7, 1'b0);
    add_item(8'h30, 8'd0, 8'd0, 8'd5, 8'd7, 1'b0);
    add_item(8'h30, 8'd0, 8'd0, 8'd5, 8'd7, 1'b0);
    add_item(8'h20, 8'd0, 8'd0, 8'd6, 8'd7, 1'b0);
    add_item(8'h30, 8'd0, 8'd0, 8'd7, 8'd7, 1'b0);
    add_item(8'h30, 8'd0, 8'd0, 8'd8, 8'd9, 1'b0);
    add_item(8'h30, 8'd0, 8'd0, 8'd8, 8'd9, 1'b0);
    add_item(8'h21, 8'd0, 8'd0, 8'd9, 8'd9, 1'b1);
    wait_quiet();

    // Random phases. Each boundary holds the sender until all results are back,
    // which is also when the registers may be rewritten.
    set_register(srcl_pkg::REG_SKIP_ENTRIES, 32'd0);
    set_register(srcl_pkg::REG_LBA_MODE, 32'd0);
    fill_random(300);
    wait_quiet();

    // Largest skip: one long section gets past all 256 leading records.
    set_register(srcl_pkg::REG_SKIP_ENTRIES, 32'd255);
    set_register(srcl_pkg::REG_LBA_MODE, 32'd1);
    queue_section(RUN_LIN, 300, 1'b1);
    fill_random(150);
    wait_quiet();

    // Receiver now faster than the sender. This phase ends with a run still held,
    // so the next settings change lands in the middle of a section.
    send_idle_pct = 55;
    recv_idle_pct = 35;
    set_register(srcl_pkg::REG_SKIP_ENTRIES, 32'd1);
    set_register(srcl_pkg::REG_LBA_MODE, 32'd0);
    fill_random(300);
    queue_section(RUN_LBA, 10, 1'b0);
    wait_quiet();

    set_register(srcl_pkg::REG_SKIP_ENTRIES, 32'd7);
    set_register(srcl_pkg::REG_LBA_MODE, 32'd1);
    fill_random(300);
    wait_quiet();

    // Back-to-back traffic on both sides, so records giving two results fill the queue.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_register(srcl_pkg::REG_SKIP_ENTRIES, 32'd0);
    set_register(srcl_pkg::REG_LBA_MODE, 32'd0);
    fill_random(300);
    wait_quiet();

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
